[sv/vwbd_pkg.sv]
// Shared types and constants for the vertex weld block.
`timescale 1ns / 1ps

package vwbd_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int POS_W      = 3 * COORD_W;
    localparam int TEX_W      = 2 * COORD_W;
    localparam int IN_DATA_W  = POS_W + TEX_W;
    localparam int OUT_IDX_W  = 10;
    localparam int OUT_DATA_W = 16;
    localparam int POS_LIM_W  = 34;
    localparam int UV_LIM_W   = 33;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 34;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_POS_LIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UV_LIM  = 2'd1;

    // Controller to datapath
    typedef struct packed {
        logic accept;  // latch a new vertex, start its scan
        logic issue;   // send the next earlier index into the compare pipeline
        logic finish;  // commit the vertex and load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;   // every earlier index issued, or store full
        logic pipe_busy;  // compare pipeline still holds candidates
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

[sv/vertex_weld_by_distance.sv]
// Top level of the vertex weld block: configuration registers, controller and datapath.
`timescale 1ns / 1ps

// Welds mesh vertices by distance. Each input transfer carries one vertex
// (Q8.8 position, Q4.12 texture coordinate) plus a first-vertex flag in
// tuser that starts a new mesh. The vertex at index v is compared with the
// representative of every earlier index p; a candidate whose squared
// position and UV distances are both within the running limits is taken
// and tightens the limits, later indices winning ties. One output transfer
// follows per vertex: the chosen index (or v itself), a merged flag, and an
// overflow flag when the store already holds MAX_VERTICES vertices.
// The result follows the scan, which reads the remap table and the vertex
// stores one entry per cycle, the five-stage distance pipeline draining, and
// the commit; nothing is scanned for the first vertex of a mesh or a full
// store. One vertex is in work at a time; the next is taken while a
// finished result still waits in the output register. A stalled receiver
// holds that result and, once the next vertex is scanned, holds the block
// before its commit. Reset empties the mesh and clears both limits to zero
// (exact duplicates only). Limits are written on the configuration channel.

module vertex_weld_by_distance
    import vwbd_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // vertex input
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic                  i_s_tuser,   // first_vertex
    // result output
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // remap_index, zero fill
    output logic [1:0]            o_m_tuser,   // merged, overflow
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    logic [POS_LIM_W-1:0] r_max_pos_dist_sq;
    logic [UV_LIM_W-1:0]  r_max_uv_dist_sq;
    logic [OUT_IDX_W-1:0] w_remap_index;
    logic                 w_merged;
    logic                 w_overflow;

    // Limits are always writable; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pos_dist_sq <= '0;
            r_max_uv_dist_sq  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POS_LIM: r_max_pos_dist_sq <= i_cfg_data[POS_LIM_W-1:0];
                REG_UV_LIM:  r_max_uv_dist_sq  <= i_cfg_data[UV_LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vwbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    vwbd_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_in_data     (i_s_tdata),
        .i_first       (i_s_tuser),
        .i_pos_lim     (r_max_pos_dist_sq),
        .i_uv_lim      (r_max_uv_dist_sq),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_remap_index (w_remap_index),
        .o_merged      (w_merged),
        .o_overflow    (w_overflow)
    );

    assign o_m_tdata = {{(OUT_DATA_W - OUT_IDX_W){1'b0}}, w_remap_index};
    assign o_m_tuser = {w_overflow, w_merged};

    // One vertex at a time: the input closes straight after a transfer.
    a_single_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a vertex is in work");

    // Commit only once every candidate has left the distance pipeline.
    a_commit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> !w_sts.pipe_busy)
        else $error("commit with candidates still in flight");

    // A full store gives index zero and no merge.
    a_overflow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (!o_m_tuser[0] && (o_m_tdata == '0)))
        else $error("overflow result carries an index or merge");

endmodule

[sv/vwbd_ctrl.sv]
// Sequencing state machine for the vertex weld block.
`timescale 1ns / 1ps

module vwbd_ctrl
    import vwbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = ST_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/vwbd_dpath.sv]
// Vertex stores, remap table, distance pipeline and output register.
`timescale 1ns / 1ps

module vwbd_dpath
    import vwbd_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_first,
    input  logic [POS_LIM_W-1:0]  i_pos_lim,
    input  logic [UV_LIM_W-1:0]   i_uv_lim,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_IDX_W-1:0]  o_remap_index,
    output logic                  o_merged,
    output logic                  o_overflow
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CNT_W = AW + 1;
    localparam int CW = (AW > OUT_IDX_W) ? AW : OUT_IDX_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    // magnitude of a - b, both signed 16 bit
    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        m = d[COORD_W] ? $unsigned(-d) : $unsigned(d);
        return m[COORD_W-1:0];
    endfunction

    // stores
    logic [POS_W-1:0] mem_pos   [0:MAX_VERTICES-1];
    logic [TEX_W-1:0] mem_tex   [0:MAX_VERTICES-1];
    logic [AW-1:0]    mem_remap [0:MAX_VERTICES-1];

    // current vertex
    logic [IN_DATA_W-1:0] r_in;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_v;
    logic                 r_full;
    logic [CNT_W-1:0]     r_p;
    logic [CNT_W-1:0]     w_v;

    // pipeline
    logic                 r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic [AW-1:0]        r_p1, r_p2, r_p3, r_p4, r_p5;
    logic [AW-1:0]        r_rmp_q;
    logic [POS_W-1:0]     r_pos_q;
    logic [TEX_W-1:0]     r_tex_q;
    logic [COORD_W-1:0]   r_dx, r_dy, r_dz, r_du, r_dv;
    logic [2*COORD_W-1:0] r_sx, r_sy, r_sz, r_su, r_sv;
    logic [POS_LIM_W-1:0] r_dp;
    logic [UV_LIM_W-1:0]  r_duv;

    // running selection
    logic [POS_LIM_W-1:0] r_pos_lim;
    logic [UV_LIM_W-1:0]  r_uv_lim;
    logic [AW-1:0]        r_choice;
    logic                 r_found;
    logic [CW-1:0]        w_choice_ext;

    // output register
    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic                 r_out_merged;
    logic                 r_out_ovf;

    assign w_v          = i_first ? '0 : r_count;
    assign w_choice_ext = CW'(r_choice);

    assign o_sts.scan_end  = r_full || (r_p >= r_v);
    assign o_sts.pipe_busy = r_vld1 | r_vld2 | r_vld3 | r_vld4 | r_vld5;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_remap_index = r_out_idx;
    assign o_merged      = r_out_merged;
    assign o_overflow    = r_out_ovf;

    // memories: one read port each, writes on commit
    always_ff @(posedge i_clk) begin
        r_rmp_q <= mem_remap[r_p[AW-1:0]];
        r_pos_q <= mem_pos[r_rmp_q];
        r_tex_q <= mem_tex[r_rmp_q];
        if (i_cmd.finish && !r_full) begin
            mem_pos[r_v[AW-1:0]]   <= r_in[POS_W-1:0];
            mem_tex[r_v[AW-1:0]]   <= r_in[IN_DATA_W-1:POS_W];
            mem_remap[r_v[AW-1:0]] <= r_choice;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_data;
        end
        r_p1 <= r_p[AW-1:0];
        r_p2 <= r_p1;
        r_p3 <= r_p2;
        r_p4 <= r_p3;
        r_p5 <= r_p4;
        r_dx <= abs_diff(r_in[15:0],  r_pos_q[15:0]);
        r_dy <= abs_diff(r_in[31:16], r_pos_q[31:16]);
        r_dz <= abs_diff(r_in[47:32], r_pos_q[47:32]);
        r_du <= abs_diff(r_in[63:48], r_tex_q[15:0]);
        r_dv <= abs_diff(r_in[79:64], r_tex_q[31:16]);
        r_sx <= (2*COORD_W)'(r_dx) * (2*COORD_W)'(r_dx);
        r_sy <= (2*COORD_W)'(r_dy) * (2*COORD_W)'(r_dy);
        r_sz <= (2*COORD_W)'(r_dz) * (2*COORD_W)'(r_dz);
        r_su <= (2*COORD_W)'(r_du) * (2*COORD_W)'(r_du);
        r_sv <= (2*COORD_W)'(r_dv) * (2*COORD_W)'(r_dv);
        r_dp  <= POS_LIM_W'(r_sx) + POS_LIM_W'(r_sy) + POS_LIM_W'(r_sz);
        r_duv <= UV_LIM_W'(r_su) + UV_LIM_W'(r_sv);
    end

    // scan control, selection and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_v         <= '0;
            r_full      <= 1'b0;
            r_p         <= '0;
            r_vld1      <= 1'b0;
            r_vld2      <= 1'b0;
            r_vld3      <= 1'b0;
            r_vld4      <= 1'b0;
            r_vld5      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_vld1 <= i_cmd.issue;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            if (i_cmd.accept) begin
                r_v    <= w_v;
                r_full <= (w_v == CNT_MAX);
                r_p    <= '0;
            end else if (i_cmd.issue) begin
                r_p <= r_p + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_count     <= r_full ? r_v : (r_v + CNT_W'(1));
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos_lim <= i_pos_lim;
            r_uv_lim  <= i_uv_lim;
            r_choice  <= w_v[AW-1:0];
            r_found   <= 1'b0;
        end else if (r_vld5 && (r_dp <= r_pos_lim) && (r_duv <= r_uv_lim)) begin
            // later candidates win ties
            r_pos_lim <= r_dp;
            r_uv_lim  <= r_duv;
            r_choice  <= r_p5;
            r_found   <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_idx    <= r_full ? '0 : w_choice_ext[OUT_IDX_W-1:0];
            r_out_merged <= !r_full && r_found;
            r_out_ovf    <= r_full;
        end
    end

endmodule
